### rtl/auto_joypad_poll_sequencer_top_macros.svh
// Assertion macros for the auto joypad poll sequencer.
`ifndef AUTO_JOYPAD_POLL_SEQUENCER_TOP_MACROS_SVH
`define AUTO_JOYPAD_POLL_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AJP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ajp assertion failed");

// Next-cycle implication, checked outside reset.
`define AJP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ajp assertion failed");

`endif

### rtl/ajp_pkg.sv
// Types and constants shared by the auto joypad poll sequencer.
package ajp_pkg;

    localparam int PAD_BITS_DEFAULT = 16;
    localparam int PAD_OUT_BITS     = 16;
    localparam int NUM_PADS         = 4;
    localparam int STEP_BITS        = 6;
    localparam int LINE_BITS        = 9;

    localparam logic [LINE_BITS-1:0] VBLANK_LINE          = 9'd225;
    localparam logic [LINE_BITS-1:0] VBLANK_LINE_OVERSCAN = 9'd240;

    // Poll train step numbers
    localparam logic [STEP_BITS-1:0] STEP_IDLE        = 6'd0;
    localparam logic [STEP_BITS-1:0] STEP_LATCH       = 6'd1;
    localparam logic [STEP_BITS-1:0] STEP_CLEAR       = 6'd2;
    localparam logic [STEP_BITS-1:0] STEP_UNLATCH     = 6'd3;
    localparam logic [STEP_BITS-1:0] STEP_SHIFT_FIRST = 6'd4;
    localparam logic [STEP_BITS-1:0] STEP_SHIFT_LAST  = 6'd34;
    localparam logic [STEP_BITS-1:0] STEP_END         = 6'd35;
    localparam logic [STEP_BITS-1:0] TRAIN_DONE       = 6'd36;

    typedef logic [PAD_OUT_BITS-1:0] pad_word_t;

    typedef struct packed {
        logic                 frame_start;
        logic [LINE_BITS-1:0] scanline;
        logic                 polarity;
        logic                 poll_enable;
        logic                 manual_latch;
        logic [1:0]           port1_data;
        logic [1:0]           port2_data;
    } ajp_in_t;

    typedef struct packed {
        logic      latch_level;
        logic      latch_rise;
        logic      busy_res;
        pad_word_t pad_one;
        pad_word_t pad_two;
        pad_word_t pad_three;
        pad_word_t pad_four;
    } ajp_res_t;

endpackage

### rtl/ajp_stream_if.sv
// Valid/ready channel carrying one word of a given payload type.
interface ajp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/ajp_in_reg.sv
// Input register: captures one tick word and holds it until the step logic takes it.
module ajp_in_reg (
    input  logic             clk,
    input  logic             rst_n,
    ajp_stream_if.sink       tick,
    input  logic             advance,
    output logic             item_valid,
    output ajp_pkg::ajp_in_t item
);

    logic             valid_reg;
    ajp_pkg::ajp_in_t item_reg;
    logic             load;

    assign tick.ready = !valid_reg || advance;
    assign load       = tick.valid && tick.ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= tick.data;
        end
    end

endmodule

### rtl/ajp_step.sv
// Poll train state: step counter, auto latch, busy flag and pad shift registers.
module ajp_step #(
    parameter int PAD_BITS = ajp_pkg::PAD_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  ajp_pkg::ajp_in_t                item,
    input  logic                            overscan_mode,
    output ajp_pkg::ajp_res_t               result,
    output logic [ajp_pkg::STEP_BITS-1:0]   poll_step
);

    logic [ajp_pkg::STEP_BITS-1:0] step_reg, step_next;
    logic                          auto_latch_reg, auto_latch_next;
    logic                          busy_reg, busy_next;
    logic [PAD_BITS-1:0]           pad_reg  [ajp_pkg::NUM_PADS];
    logic [PAD_BITS-1:0]           pad_next [ajp_pkg::NUM_PADS];

    logic [ajp_pkg::STEP_BITS-1:0] step_cleared;
    logic [ajp_pkg::STEP_BITS-1:0] step_cur;
    logic [ajp_pkg::LINE_BITS-1:0] first_line;
    logic [ajp_pkg::NUM_PADS-1:0]  feed;
    logic                          start;
    logic                          in_train;
    logic                          abort;
    logic                          shift;
    logic                          rise;

    assign poll_step = step_reg;

    // Bit order of feed follows pad one, two, three, four.
    assign feed = {item.port2_data[1], item.port1_data[1],
                   item.port2_data[0], item.port1_data[0]};

    always_comb
    begin
        first_line   = overscan_mode ? ajp_pkg::VBLANK_LINE_OVERSCAN : ajp_pkg::VBLANK_LINE;
        step_cleared = item.frame_start ? ajp_pkg::STEP_IDLE : step_reg;
        start        = (item.scanline >= first_line) && !item.polarity
                       && (step_cleared == ajp_pkg::STEP_IDLE);
        if (start)
        begin
            step_cur = item.poll_enable ? ajp_pkg::STEP_LATCH : ajp_pkg::TRAIN_DONE;
        end
        else
        begin
            step_cur = step_cleared;
        end

        in_train = (step_cur != ajp_pkg::STEP_IDLE) && (step_cur < ajp_pkg::TRAIN_DONE);
        abort    = !item.poll_enable && in_train;
        shift    = (step_cur >= ajp_pkg::STEP_SHIFT_FIRST)
                   && (step_cur <= ajp_pkg::STEP_SHIFT_LAST) && !step_cur[0];

        step_next       = step_cur;
        auto_latch_next = auto_latch_reg;
        busy_next       = busy_reg;
        rise            = 1'b0;
        for (int i = 0; i < ajp_pkg::NUM_PADS; i++)
        begin
            pad_next[i] = pad_reg[i];
        end

        if (abort)
        begin
            step_next       = ajp_pkg::TRAIN_DONE;
            busy_next       = 1'b0;
            auto_latch_next = 1'b0;
        end
        else
        begin
            if (step_cur == ajp_pkg::STEP_LATCH)
            begin
                auto_latch_next = 1'b1;
                rise            = !(auto_latch_reg || item.manual_latch);
            end
            if (step_cur == ajp_pkg::STEP_CLEAR)
            begin
                busy_next = 1'b1;
                for (int i = 0; i < ajp_pkg::NUM_PADS; i++)
                begin
                    pad_next[i] = '0;
                end
            end
            if (step_cur == ajp_pkg::STEP_UNLATCH)
            begin
                auto_latch_next = 1'b0;
            end
            if (shift)
            begin
                for (int i = 0; i < ajp_pkg::NUM_PADS; i++)
                begin
                    pad_next[i] = {pad_reg[i][PAD_BITS-2:0], feed[i]};
                end
            end
            if (step_cur == ajp_pkg::STEP_END)
            begin
                busy_next = 1'b0;
            end
            if (in_train)
            begin
                step_next = step_cur + ajp_pkg::STEP_BITS'(1);
            end
        end

        result.latch_level = auto_latch_next || item.manual_latch;
        result.latch_rise  = rise;
        result.busy_res    = busy_next;
        result.pad_one     = ajp_pkg::pad_word_t'(pad_next[0]);
        result.pad_two     = ajp_pkg::pad_word_t'(pad_next[1]);
        result.pad_three   = ajp_pkg::pad_word_t'(pad_next[2]);
        result.pad_four    = ajp_pkg::pad_word_t'(pad_next[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= ajp_pkg::STEP_IDLE;
            auto_latch_reg <= 1'b0;
            busy_reg       <= 1'b0;
            for (int i = 0; i < ajp_pkg::NUM_PADS; i++)
            begin
                pad_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            step_reg       <= step_next;
            auto_latch_reg <= auto_latch_next;
            busy_reg       <= busy_next;
            for (int i = 0; i < ajp_pkg::NUM_PADS; i++)
            begin
                pad_reg[i] <= pad_next[i];
            end
        end
    end

endmodule

### rtl/ajp_out_reg.sv
// Result register: holds one report word until the sink takes it.
module ajp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    ajp_stream_if.source      report,
    input  logic              load,
    input  ajp_pkg::ajp_res_t result,
    output logic              can_load
);

    logic              valid_reg;
    ajp_pkg::ajp_res_t result_reg;

    assign can_load     = !valid_reg || report.ready;
    assign report.valid = valid_reg;
    assign report.data  = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

### rtl/auto_joypad_poll_sequencer_top.sv
// Top level of the auto joypad poll sequencer.
// Takes one tick word per clock unless the report side stalls, and returns one report
// word per tick: the tick waits in the input register, then the step update lands in
// the result register. Throughput is one word per cycle; a stalled report only holds
// the input side once both registers are full. The overscan register write is always
// ready and is expected while idle.
`include "auto_joypad_poll_sequencer_top_macros.svh"

module auto_joypad_poll_sequencer_top #(
    parameter int PAD_BITS = ajp_pkg::PAD_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    ajp_stream_if.sink    cfg,
    ajp_stream_if.sink    tick,
    ajp_stream_if.source  report
);

    logic                          overscan_mode_reg;
    logic                          item_valid;
    ajp_pkg::ajp_in_t              item;
    ajp_pkg::ajp_res_t             result;
    logic                          can_load;
    logic                          fire;
    logic [ajp_pkg::STEP_BITS-1:0] poll_step;

    assign cfg.ready = 1'b1;
    assign fire      = item_valid && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overscan_mode_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            overscan_mode_reg <= cfg.data;
        end
    end

    ajp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    ajp_step #(
        .PAD_BITS (PAD_BITS)
    ) u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .item          (item),
        .overscan_mode (overscan_mode_reg),
        .result        (result),
        .poll_step     (poll_step)
    );

    ajp_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .report   (report),
        .load     (fire),
        .result   (result),
        .can_load (can_load)
    );

    // A rising latch always moves the train on to the pad clear step.
    `AJP_ASSERT_NEXT(a_rise_then_clear, clk, rst_n, fire && result.latch_rise, poll_step == ajp_pkg::STEP_CLEAR)
    // The step counter never passes the resting value.
    `AJP_ASSERT_SAME(a_step_bound, clk, rst_n, 1'b1, poll_step <= ajp_pkg::TRAIN_DONE)
    // A new report only appears after a step update.
    `AJP_ASSERT_SAME(a_report_from_fire, clk, rst_n, $rose(report.valid), $past(fire))

endmodule
